// ----- src/dcc_pkg.sv -----
package dcc_pkg;

   localparam int unsigned DCC_CHANNEL_W = 8;
   localparam int unsigned DCC_COUNT_W   = 25;
   localparam int unsigned DCC_LANE_BITS = 3;
   localparam int unsigned DCC_BYTE_W    = 8;

   localparam logic DCC_OP_INSERT = 1'b0;
   localparam logic DCC_OP_PROBE  = 1'b1;

   typedef struct packed {
      logic                     op;
      logic [DCC_CHANNEL_W-1:0] red;
      logic [DCC_CHANNEL_W-1:0] green;
      logic [DCC_CHANNEL_W-1:0] blue;
   } dcc_req_type;

   typedef struct packed {
      logic                   was_seen;
      logic [DCC_COUNT_W-1:0] distinct_count;
   } dcc_rsp_type;

   typedef enum logic {
      DCC_ST_CLEAR,
      DCC_ST_RUN
   } dcc_state_type;

endpackage

// ----- src/dcc_bitmap_ram.sv -----
module dcc_bitmap_ram #(
   parameter int unsigned ADDR_W = 21
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [ADDR_W-1:0]               wr_addr,
   input  logic [dcc_pkg::DCC_BYTE_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]               rd_addr,
   output logic [dcc_pkg::DCC_BYTE_W-1:0]  rd_data
);
   import dcc_pkg::*;

   localparam int unsigned DEPTH = 1 << ADDR_W;

   logic [DCC_BYTE_W-1:0] mem [DEPTH];
   logic [DCC_BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/dcc_clear_seq.sv -----
module dcc_clear_seq #(
   parameter int unsigned ADDR_W = 21
) (
   input  logic              clock,
   input  logic              reset,
   output logic              clear_active,
   output logic [ADDR_W-1:0] clear_addr
);
   import dcc_pkg::*;

   dcc_state_type     state_ff;
   dcc_state_type     state_in;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] addr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DCC_ST_CLEAR;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      clear_active = 1'b0;
      case (state_ff)
         DCC_ST_CLEAR: begin
            clear_active = 1'b1;
            addr_in      = addr_ff + ADDR_W'(1);
            if (addr_ff == {ADDR_W{1'b1}}) begin
               state_in = DCC_ST_RUN;
            end
         end
         DCC_ST_RUN: begin
            clear_active = 1'b0;
         end
         default: begin
            state_in = DCC_ST_CLEAR;
            addr_in  = '0;
         end
      endcase
   end

   assign clear_addr = addr_ff;

endmodule

// ----- src/distinct_color_counter_core.sv -----
// Distinct color counter.
// Input: present an item on req_item with start high; it is taken at a
// rising edge where start is high and busy is low. op insert sets the
// color's presence bit, op probe only reads it.
// Output: one result per item, shown on rsp_item for exactly one cycle with
// rsp_valid high. The receiver cannot stall; every result must be taken.
// Timing: accept registers the item into stage 1, which registers rsp_item.
// Throughput: one item per cycle while busy is low. The bitmap RAM is read
// at accept and written back in the following cycle; a bypass register
// covers back-to-back items hitting the same byte.
// Reset: busy rises and a clearing pass zeroes all 2^(COLOR_BITS-3) bytes
// of the bitmap (2097152 at the default) one byte per cycle, then busy drops.
// The distinct count resets to zero.
// Narrow keys: with COLOR_BITS below 24 only the low COLOR_BITS bits of
// {blue, green, red} select a bit.
module distinct_color_counter_core #(
   parameter int unsigned COLOR_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  dcc_pkg::dcc_req_type req_item,
   output logic                 rsp_valid,
   output dcc_pkg::dcc_rsp_type rsp_item
);
   import dcc_pkg::*;

   localparam int unsigned ADDR_W = COLOR_BITS - DCC_LANE_BITS;
   localparam int unsigned CNT_W  = COLOR_BITS + 1;

   logic [3*DCC_CHANNEL_W-1:0] full_key;
   logic [COLOR_BITS-1:0]      key;
   logic                       accept;

   logic                       clear_active;
   logic [ADDR_W-1:0]          clear_addr;

   logic                       mem_we;
   logic [ADDR_W-1:0]          mem_wa;
   logic [DCC_BYTE_W-1:0]      mem_wd;
   logic [DCC_BYTE_W-1:0]      mem_rd;

   logic                       s1_valid_ff;
   logic                       s1_op_ff;
   logic [ADDR_W-1:0]          s1_addr_ff;
   logic [DCC_LANE_BITS-1:0]   s1_lane_ff;

   logic                       fwd_valid_ff;
   logic [ADDR_W-1:0]          fwd_addr_ff;
   logic [DCC_BYTE_W-1:0]      fwd_data_ff;

   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;

   logic                       rsp_valid_ff;
   dcc_rsp_type                rsp_item_ff;

   logic [DCC_BYTE_W-1:0]      cur_byte;
   logic [DCC_BYTE_W-1:0]      lane_mask;
   logic [DCC_BYTE_W-1:0]      new_byte;
   logic                       seen;
   logic                       set_bit;

   assign full_key = {req_item.blue, req_item.green, req_item.red};
   assign key      = full_key[COLOR_BITS-1:0];
   assign accept   = start && !busy;
   assign busy     = clear_active;

   dcc_clear_seq #(
      .ADDR_W(ADDR_W)
   ) u_clear (
      .clock       (clock),
      .reset       (reset),
      .clear_active(clear_active),
      .clear_addr  (clear_addr)
   );

   dcc_bitmap_ram #(
      .ADDR_W(ADDR_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_wa),
      .wr_data(mem_wd),
      .rd_addr(key[COLOR_BITS-1:DCC_LANE_BITS]),
      .rd_data(mem_rd)
   );

   // stage 1: merge bypass, test and set
   always_comb begin
      cur_byte  = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : mem_rd;
      lane_mask = DCC_BYTE_W'(1) << s1_lane_ff;
      seen      = |(cur_byte & lane_mask);
      set_bit   = s1_valid_ff && (s1_op_ff == DCC_OP_INSERT) && !seen;
      new_byte  = set_bit ? (cur_byte | lane_mask) : cur_byte;
      count_in  = set_bit ? (count_ff + CNT_W'(1)) : count_ff;
   end

   always_comb begin
      if (clear_active) begin
         mem_we = 1'b1;
         mem_wa = clear_addr;
         mem_wd = '0;
      end else begin
         mem_we = set_bit;
         mem_wa = s1_addr_ff;
         mem_wd = new_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= accept;
         fwd_valid_ff <= s1_valid_ff;
         rsp_valid_ff <= s1_valid_ff;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff                   <= req_item.op;
      s1_addr_ff                 <= key[COLOR_BITS-1:DCC_LANE_BITS];
      s1_lane_ff                 <= key[DCC_LANE_BITS-1:0];
      fwd_addr_ff                <= s1_addr_ff;
      fwd_data_ff                <= new_byte;
      rsp_item_ff.was_seen       <= seen;
      rsp_item_ff.distinct_count <= DCC_COUNT_W'(count_in);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("accepted item produced no result");

   a_no_work_while_clearing: assert property (@(posedge clock) disable iff (reset)
      busy |-> !s1_valid_ff && !rsp_valid)
      else $error("item in flight during bitmap clear");

   a_seen_keeps_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.was_seen |-> count_ff == $past(count_ff))
      else $error("count changed on a color already seen");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.distinct_count == DCC_COUNT_W'(count_ff))
      else $error("reported count differs from running count");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import dcc_pkg::*;

   localparam int unsigned KEY_W        = 24;
   localparam int unsigned KEY_MASK     = (1 << KEY_W) - 1;
   localparam int unsigned CLEAR_CYCLES = 1 << (KEY_W - 3);
   localparam int unsigned STALL_LIMIT  = 4 * CLEAR_CYCLES + 4000;
   localparam int unsigned PHASE_ITEMS  = 310;
   localparam int unsigned MAX_REPORTS  = 10;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   dcc_req_type req_item  = '0;
   logic        busy;
   logic        rsp_valid;
   dcc_rsp_type rsp_item;

   dcc_req_type            pixel_q[$];
   dcc_rsp_type            count_q[$];
   bit                     color_seen[int unsigned];
   logic [DCC_COUNT_W-1:0] distinct_total = '0;
   int unsigned            inserted_keys[$];
   int unsigned            idle_pct     = 0;
   int unsigned            queued_items = 0;
   int unsigned            mismatches   = 0;
   int unsigned            quiet_cycles = 0;

   distinct_color_counter_core #(
      .COLOR_BITS(KEY_W)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   always #5 clock = ~clock;

   function automatic dcc_rsp_type tally_pixel(dcc_req_type px);
      int unsigned key;
      dcc_rsp_type rsp;
      key = {px.blue, px.green, px.red} & KEY_MASK;
      rsp.was_seen = color_seen.exists(key);
      if (px.op == DCC_OP_INSERT && !rsp.was_seen) begin
         color_seen[key] = 1'b1;
         distinct_total  = distinct_total + 1'b1;
      end
      rsp.distinct_count = distinct_total;
      return rsp;
   endfunction

   task automatic note_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t: mismatch: %s", $realtime, msg);
      end
   endtask

   task automatic push_pixel(logic op, int unsigned key);
      dcc_req_type px;
      px.op = op;
      {px.blue, px.green, px.red} = key[23:0];
      pixel_q.push_back(px);
      queued_items++;
      if (op == DCC_OP_INSERT) begin
         inserted_keys.push_back(key & 32'hFFFFFF);
      end
   endtask

   task automatic push_random_run(int unsigned window_base);
      int unsigned sel;
      int unsigned key;
      int unsigned n;
      sel = $urandom_range(99);
      if ($urandom_range(1)) begin
         key = $urandom() & 32'hFFFFFF;
      end else begin
         key = (window_base + $urandom_range(255)) & 32'hFFFFFF;
      end
      if (sel < 30) begin
         push_pixel(DCC_OP_INSERT, key);
      end else if (sel < 50 && inserted_keys.size() != 0) begin
         push_pixel(DCC_OP_INSERT, inserted_keys[$urandom_range(inserted_keys.size() - 1)]);
      end else if (sel < 65 && inserted_keys.size() != 0) begin
         push_pixel(DCC_OP_PROBE, inserted_keys[$urandom_range(inserted_keys.size() - 1)]);
      end else if (sel < 75) begin
         push_pixel(DCC_OP_PROBE, key);
      end else begin
         // burst within one bitmap byte, back to back
         n = $urandom_range(6, 2);
         repeat (n) begin
            push_pixel(1'($urandom_range(1)), (key & 32'hFFFFF8) | $urandom_range(7));
         end
      end
   endtask

   task automatic wait_drained();
      while (pixel_q.size() != 0 || count_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      logic taken;
      logic offer;
      taken = start && !busy;
      if (taken) begin
         count_q.push_back(tally_pixel(pixel_q.pop_front()));
      end
      offer = start && !taken;
      if (!offer && !reset && pixel_q.size() != 0) begin
         offer = $urandom_range(99) >= idle_pct;
      end
      start <= offer;
      if (offer) begin
         req_item <= pixel_q[0];
      end
   end

   always @(posedge clock) begin
      dcc_rsp_type want;
      if (rsp_valid) begin
         if (count_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result was_seen %0b count %0d",
                                    rsp_item.was_seen, rsp_item.distinct_count));
         end else begin
            want = count_q.pop_front();
            if (rsp_item.was_seen !== want.was_seen) begin
               note_mismatch($sformatf("was_seen expected %0b got %0b",
                                       want.was_seen, rsp_item.was_seen));
            end
            if (rsp_item.distinct_count !== want.distinct_count) begin
               note_mismatch($sformatf("distinct_count expected %0d got %0d",
                                       want.distinct_count, rsp_item.distinct_count));
            end
         end
      end
   end

   // covers the bitmap clearing pass after reset
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned phase_idle[4];
      int unsigned window_base;
      phase_idle = '{0, 67, 28, 0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_pixel(DCC_OP_PROBE,  24'h000000);
      push_pixel(DCC_OP_INSERT, 24'h000000);
      push_pixel(DCC_OP_INSERT, 24'h000000);
      push_pixel(DCC_OP_PROBE,  24'h000000);
      push_pixel(DCC_OP_INSERT, 24'hFFFFFF);
      push_pixel(DCC_OP_PROBE,  24'hFFFFFF);
      push_pixel(DCC_OP_INSERT, 24'hFFFFFE);
      push_pixel(DCC_OP_INSERT, 24'hFFFFF8);
      push_pixel(DCC_OP_PROBE,  24'hFFFFF9);
      push_pixel(DCC_OP_INSERT, 24'h000001);
      push_pixel(DCC_OP_INSERT, 24'h000007);
      push_pixel(DCC_OP_INSERT, 24'h000001);
      push_pixel(DCC_OP_INSERT, 24'h0000FF);
      push_pixel(DCC_OP_INSERT, 24'h00FF00);
      push_pixel(DCC_OP_INSERT, 24'hFF0000);
      push_pixel(DCC_OP_PROBE,  24'h00FF01);
      push_pixel(DCC_OP_INSERT, 24'h800000);
      push_pixel(DCC_OP_INSERT, 24'h000080);
      push_pixel(DCC_OP_PROBE,  24'h0000FF);
      push_pixel(DCC_OP_INSERT, 24'hAA55AA);
      push_pixel(DCC_OP_INSERT, 24'h55AA55);
      push_pixel(DCC_OP_PROBE,  24'h55AA55);
      wait_drained();

      foreach (phase_idle[p]) begin
         @(negedge clock);
         idle_pct     = phase_idle[p];
         window_base  = $urandom() & 32'hFFFF00;
         queued_items = 0;
         while (queued_items < PHASE_ITEMS) begin
            push_random_run(window_base);
         end
         wait_drained();
      end

      repeat (8) @(negedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
